// File: hdl/pmne_pkg.sv
// Shared types, constants and microcode ROM for the polynomial multiplier.
package pmne_pkg;

    // Fixed field widths of the item ports
    localparam int DEG_W   = 5;
    localparam int COEF_W  = 16;
    localparam int OUT_W   = 37;
    localparam int FUNC_W  = 2;

    // Function codes of an input item
    localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL    = 2'd2;

    // Microcode address
    localparam int UA_W = 4;
    typedef logic [UA_W-1:0] uaddr_t;

    localparam uaddr_t UA_IDLE    = 4'd0;
    localparam uaddr_t UA_SETUP   = 4'd1;
    localparam uaddr_t UA_FETCH   = 4'd2;
    localparam uaddr_t UA_FLUSH1  = 4'd3;
    localparam uaddr_t UA_FLUSH2  = 4'd4;
    localparam uaddr_t UA_DRAIN   = 4'd5;
    localparam uaddr_t UA_EMIT_RD = 4'd6;
    localparam uaddr_t UA_EMIT    = 4'd7;
    localparam uaddr_t UA_CLEAR   = 4'd8;

    // Jump conditions; a true condition loads the target, else fall through
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_FETCH_MORE,
        C_DRAIN_MORE,
        C_NONE_FOUND,
        C_EMIT_MORE
    } cond_t;

    // Datapath strobes of one microcode step
    typedef struct packed {
        logic clr;         // clear lanes, counters and nonzero tracking
        logic fetch;       // read one first-operand term into the lane row
        logic drain;       // shift the lane row out without adding
        logic emit_start;  // read the highest product degree
        logic emit;        // emit stage active
        logic clear_ops;   // zero both operand stores
    } ctrl_t;

    typedef struct packed {
        ctrl_t  ctrl;
        cond_t  cond;
        uaddr_t target;
    } uword_t;

    // Status fed back to the sequencer
    typedef struct packed {
        logic start;       // multiply transfer this cycle
        logic none_found;  // product is all zero
        logic emit_last;   // lowest nonzero coefficient leaves this cycle
    } status_t;

    localparam ctrl_t CTRL_NONE = '{default: 1'b0};

    // Microcode ROM
    function automatic uword_t ucode_word(input uaddr_t ua);
        uword_t w;
        w = '{ctrl: CTRL_NONE, cond: C_ALWAYS, target: UA_IDLE};
        unique case (ua)
            UA_IDLE:
            begin
                w.cond   = C_NO_START;
                w.target = UA_IDLE;
            end
            UA_SETUP:
            begin
                w.ctrl.clr = 1'b1;
                w.cond     = C_NEVER;
            end
            UA_FETCH:
            begin
                w.ctrl.fetch = 1'b1;
                w.cond       = C_FETCH_MORE;
                w.target     = UA_FETCH;
            end
            UA_FLUSH1:
            begin
                w.cond = C_NEVER;
            end
            UA_FLUSH2:
            begin
                w.cond = C_NEVER;
            end
            UA_DRAIN:
            begin
                w.ctrl.drain = 1'b1;
                w.cond       = C_DRAIN_MORE;
                w.target     = UA_DRAIN;
            end
            UA_EMIT_RD:
            begin
                w.ctrl.emit_start = 1'b1;
                w.cond            = C_NONE_FOUND;
                w.target          = UA_CLEAR;
            end
            UA_EMIT:
            begin
                w.ctrl.emit = 1'b1;
                w.cond      = C_EMIT_MORE;
                w.target    = UA_EMIT;
            end
            UA_CLEAR:
            begin
                w.ctrl.clear_ops = 1'b1;
                w.cond           = C_ALWAYS;
                w.target         = UA_IDLE;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: hdl/pmne_useq.sv
// Microcode sequencer: program counter, loop counter and jump logic.
module pmne_useq #(
    parameter int TERMS = 32,
    parameter int CW    = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pmne_pkg::status_t  st,
    output pmne_pkg::ctrl_t    ctrl,
    output logic [CW-1:0]      cnt,
    output logic               idle
);

    pmne_pkg::uaddr_t upc_reg;
    pmne_pkg::uaddr_t upc_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    pmne_pkg::uword_t word;
    logic             hit;

    // Decode the current step and pick the next one
    always_comb
    begin
        word = pmne_pkg::ucode_word(upc_reg);
        unique case (word.cond)
            pmne_pkg::C_NEVER:      hit = 1'b0;
            pmne_pkg::C_ALWAYS:     hit = 1'b1;
            pmne_pkg::C_NO_START:   hit = !st.start;
            pmne_pkg::C_FETCH_MORE: hit = (cnt_reg != CW'(TERMS - 1));
            pmne_pkg::C_DRAIN_MORE: hit = (cnt_reg != CW'(TERMS - 2));
            pmne_pkg::C_NONE_FOUND: hit = st.none_found;
            pmne_pkg::C_EMIT_MORE:  hit = !st.emit_last;
            default:                hit = 1'b0;
        endcase
        upc_next = hit ? word.target : upc_reg + pmne_pkg::uaddr_t'(1);

        // Loop counter steps while a loop repeats, restarts when it exits
        cnt_next = cnt_reg;
        if (word.ctrl.clr)
        begin
            cnt_next = '0;
        end
        else if (word.ctrl.fetch || word.ctrl.drain)
        begin
            cnt_next = hit ? cnt_reg + CW'(1) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= pmne_pkg::UA_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            upc_reg <= upc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign ctrl = word.ctrl;
    assign cnt  = cnt_reg;
    assign idle = (upc_reg == pmne_pkg::UA_IDLE);

endmodule

// File: hdl/pmne_mac_row.sv
// Row of multiply-accumulate lanes; finished degrees shift out of lane 0.
module pmne_mac_row #(
    parameter int TERMS      = 32,
    parameter int COEFF_BITS = 16,
    parameter int AW         = 37
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pmne_pkg::ctrl_t              ctrl,
    input  logic signed [COEFF_BITS-1:0] a_in,
    input  logic signed [COEFF_BITS-1:0] sec [TERMS],
    output logic                         wr_en,
    output logic signed [AW-1:0]         wr_val
);

    localparam int PW = 2 * COEFF_BITS;

    logic signed [COEFF_BITS-1:0] a_reg;
    logic                         v1_reg;
    logic                         v2_reg;
    logic signed [PW-1:0]         prod_reg [TERMS];
    logic signed [AW-1:0]         lane_reg [TERMS];
    logic signed [AW-1:0]         sum      [TERMS];

    // Valid flags of the fetch and multiply stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.fetch;
            v2_reg <= v1_reg;
        end
    end

    // Fetched term and per-lane products
    always_ff @(posedge clk)
    begin
        if (ctrl.fetch)
        begin
            a_reg <= a_in;
        end
        if (v1_reg)
        begin
            for (int j = 0; j < TERMS; j++)
            begin
                prod_reg[j] <= a_reg * sec[j];
            end
        end
    end

    // Lane j holds the running sum of degree (step + j)
    always_comb
    begin
        for (int j = 0; j < TERMS; j++)
        begin
            sum[j] = lane_reg[j] + AW'(prod_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clr)
        begin
            for (int j = 0; j < TERMS; j++)
            begin
                lane_reg[j] <= '0;
            end
        end
        else if (v2_reg)
        begin
            for (int j = 0; j < TERMS - 1; j++)
            begin
                lane_reg[j] <= sum[j + 1];
            end
            lane_reg[TERMS-1] <= '0;
        end
        else if (ctrl.drain)
        begin
            for (int j = 0; j < TERMS - 1; j++)
            begin
                lane_reg[j] <= lane_reg[j + 1];
            end
            lane_reg[TERMS-1] <= '0;
        end
    end

    assign wr_en  = v2_reg || ctrl.drain;
    assign wr_val = v2_reg ? sum[0] : lane_reg[0];

endmodule

// File: hdl/pmne_emit.sv
// Product memory, lowest-nonzero tracking and the result output register.
module pmne_emit #(
    parameter int TERMS = 32,
    parameter int AW    = 37
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pmne_pkg::ctrl_t                     ctrl,
    input  logic                                wr_en,
    input  logic signed [AW-1:0]                wr_val,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic signed [pmne_pkg::OUT_W-1:0]   product_coeff,
    output logic                                is_last,
    output logic                                none_found,
    output logic                                emit_last
);

    localparam int DEPTH = 2 * TERMS - 1;
    localparam int MA    = $clog2(DEPTH);
    localparam int OW    = pmne_pkg::OUT_W;
    localparam logic [MA-1:0] TOP = MA'(DEPTH - 1);

    logic signed [AW-1:0] mem [DEPTH];
    logic signed [AW-1:0] rd_reg;
    logic [MA-1:0]        waddr_reg;
    logic [MA-1:0]        raddr_reg;
    logic [MA-1:0]        lowest_reg;
    logic                 found_reg;
    logic                 valid_reg;
    logic signed [OW-1:0] coeff_reg;
    logic                 last_reg;
    logic                 free;
    logic                 at_lowest;
    logic                 adv;
    logic                 rd_en;
    logic [MA-1:0]        rd_addr;

    assign free      = !valid_reg || !out_stall;
    assign at_lowest = (raddr_reg == lowest_reg);
    assign adv       = ctrl.emit && free;
    assign rd_en     = ctrl.emit_start || (adv && !at_lowest);
    assign rd_addr   = ctrl.emit_start ? TOP : raddr_reg - MA'(1);

    // Product memory: degrees written in ascending order, read top down
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr_reg] <= wr_val;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Write pointer, read pointer and lowest nonzero degree
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waddr_reg  <= '0;
            raddr_reg  <= '0;
            lowest_reg <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.clr)
            begin
                waddr_reg <= '0;
                found_reg <= 1'b0;
            end
            else if (wr_en)
            begin
                waddr_reg <= waddr_reg + MA'(1);
                if (wr_val != '0 && !found_reg)
                begin
                    found_reg  <= 1'b1;
                    lowest_reg <= waddr_reg;
                end
            end
            if (rd_en)
            begin
                raddr_reg <= rd_addr;
            end
        end
    end

    // Output register; zero coefficients are skipped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= (rd_reg != '0);
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            coeff_reg <= OW'(rd_reg);
            last_reg  <= at_lowest;
        end
    end

    assign out_valid     = valid_reg;
    assign product_coeff = coeff_reg;
    assign is_last       = last_reg;
    assign none_found    = !found_reg;
    assign emit_last     = free && at_lowest;

endmodule

// File: hdl/polynomial_multiply_nonzero_emit.sv
// Top level: operand stores, microcode sequencer, MAC lane row and emitter.
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+-------------------------------
//   input   | in  | in_valid / in_stall     | func, degree, coeff
//   result  | out | out_valid / out_stall   | product_coeff, is_last
//
// A load transfer leaves the block ready for the next item.
// A multiply runs the microcode: setup, fetch of every first-operand term,
// two flush steps, drain of the lane row, read of the top degree, then one
// degree per cycle from the top down to the lowest nonzero one while out_stall
// does not hold the output register (none if all zero), and a clear step.
// in_stall is high from the cycle after a multiply transfer until its end.
// Reset empties both operand stores and the pipeline; no clearing pass runs.
module polynomial_multiply_nonzero_emit #(
    parameter int TERMS      = 32,
    parameter int COEFF_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pmne_pkg::FUNC_W-1:0]         func,
    input  logic [pmne_pkg::DEG_W-1:0]          degree,
    input  logic signed [pmne_pkg::COEF_W-1:0]  coeff,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pmne_pkg::OUT_W-1:0]   product_coeff,
    output logic                                is_last
);

    localparam int CW = $clog2(TERMS);
    localparam int AW = 2 * COEFF_BITS + CW;

    pmne_pkg::ctrl_t   ctrl;
    pmne_pkg::status_t st;
    logic [CW-1:0]     cnt;
    logic              idle;
    logic              accept;
    logic              in_range;
    logic signed [COEFF_BITS-1:0] cval;

    logic signed [COEFF_BITS-1:0] a_coef_reg [TERMS];
    logic signed [COEFF_BITS-1:0] b_coef_reg [TERMS];
    logic [TERMS-1:0]             a_vld_reg;
    logic [TERMS-1:0]             b_vld_reg;
    logic signed [COEFF_BITS-1:0] a_in;
    logic signed [COEFF_BITS-1:0] sec [TERMS];

    logic                 wr_en;
    logic signed [AW-1:0] wr_val;
    logic                 none_found;
    logic                 emit_last;

    assign in_stall = !idle;
    assign accept   = in_valid && idle;
    assign in_range = ({1'b0, degree} < (pmne_pkg::DEG_W + 1)'(TERMS));
    assign cval     = COEFF_BITS'(coeff);

    assign st.start      = accept && (func == pmne_pkg::FUNC_MUL);
    assign st.none_found = none_found;
    assign st.emit_last  = emit_last;

    // Valid bits of the operand stores; a term not loaded reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= '0;
            b_vld_reg <= '0;
        end
        else if (ctrl.clear_ops)
        begin
            a_vld_reg <= '0;
            b_vld_reg <= '0;
        end
        else if (accept && in_range)
        begin
            if (func == pmne_pkg::FUNC_LOAD_A)
            begin
                a_vld_reg[degree[CW-1:0]] <= 1'b1;
            end
            if (func == pmne_pkg::FUNC_LOAD_B)
            begin
                b_vld_reg[degree[CW-1:0]] <= 1'b1;
            end
        end
    end

    // Operand coefficient stores
    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            if (func == pmne_pkg::FUNC_LOAD_A)
            begin
                a_coef_reg[degree[CW-1:0]] <= cval;
            end
            if (func == pmne_pkg::FUNC_LOAD_B)
            begin
                b_coef_reg[degree[CW-1:0]] <= cval;
            end
        end
    end

    // Operand reads: one first-operand term per step, all second terms in lanes
    always_comb
    begin
        a_in = a_vld_reg[cnt] ? a_coef_reg[cnt] : '0;
        for (int j = 0; j < TERMS; j++)
        begin
            sec[j] = b_vld_reg[j] ? b_coef_reg[j] : '0;
        end
    end

    pmne_useq #(
        .TERMS (TERMS),
        .CW    (CW)
    ) u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctrl  (ctrl),
        .cnt   (cnt),
        .idle  (idle)
    );

    pmne_mac_row #(
        .TERMS      (TERMS),
        .COEFF_BITS (COEFF_BITS),
        .AW         (AW)
    ) u_mac_row (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .a_in   (a_in),
        .sec    (sec),
        .wr_en  (wr_en),
        .wr_val (wr_val)
    );

    pmne_emit #(
        .TERMS (TERMS),
        .AW    (AW)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .wr_en         (wr_en),
        .wr_val        (wr_val),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .product_coeff (product_coeff),
        .is_last       (is_last),
        .none_found    (none_found),
        .emit_last     (emit_last)
    );

endmodule

// File: hdl/pmne_check.sv
// Port-level checker for the polynomial multiplier, bound to the top level.
module pmne_check (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic [pmne_pkg::FUNC_W-1:0]         func,
    input logic [pmne_pkg::DEG_W-1:0]          degree,
    input logic signed [pmne_pkg::COEF_W-1:0]  coeff,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [pmne_pkg::OUT_W-1:0]   product_coeff,
    input logic                                is_last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(product_coeff) && $stable(is_last))
        else $error("stalled result changed");

    // A multiply transfer makes the block busy
    a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func == pmne_pkg::FUNC_MUL |=> in_stall)
        else $error("multiply did not start");

    // A load transfer leaves the block ready
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func != pmne_pkg::FUNC_MUL |=> !in_stall)
        else $error("load stalled the input");

    // New results appear only while a multiply is running
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_stall)
        else $error("result outside a multiply");

endmodule

bind polynomial_multiply_nonzero_emit pmne_check u_pmne_check (.*);
